FILE: src/skst_pkg.sv
`default_nettype none
package skst_pkg;

  localparam int FUNC_W   = 2;
  localparam int KEY_W    = 31;
  localparam int STATUS_W = 2;
  localparam int POS_W    = 7;

  typedef logic [FUNC_W-1:0]   func_t;
  typedef logic [KEY_W-1:0]    key_t;
  typedef logic [POS_W-1:0]    pos_t;

  // Operation codes; the unused code is served as a lookup.
  typedef enum logic [FUNC_W-1:0] {
    OP_LOOKUP = 2'd0,
    OP_INSERT = 2'd1,
    OP_DELETE = 2'd2
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE   = 2'd0,
    ST_ABSENT = 2'd1,
    ST_DUP    = 2'd2,
    ST_FULL   = 2'd3
  } status_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_LOOK,
    S_CMP,
    S_INS_RD,
    S_INS_WR,
    S_INS_PUT,
    S_DEL_RD,
    S_DEL_WR,
    S_DEL_FIN,
    S_DONE
  } state_t;

endpackage
`default_nettype wire

FILE: src/skst_req_if.sv
`default_nettype none
interface skst_req_if;
  logic               valid;
  logic               ready;
  skst_pkg::func_t    func;
  skst_pkg::key_t     key;

  modport source (output valid, output func, output key, input ready);
  modport sink   (input valid, input func, input key, output ready);
endinterface
`default_nettype wire

FILE: src/skst_rsp_if.sv
`default_nettype none
interface skst_rsp_if;
  logic               valid;
  logic               ready;
  skst_pkg::status_t  status;
  skst_pkg::pos_t     position;
  skst_pkg::pos_t     entry_count;

  modport source (output valid, output status, output position, output entry_count,
                  input ready);
  modport sink   (input valid, input status, input position, input entry_count,
                  output ready);
endinterface
`default_nettype wire

FILE: src/sorted_key_set_table.sv
`default_nettype none
// Sorted key set table. Keeps up to CAPACITY unique keys in ascending order
// in one simple dual-port RAM.
// Request channel (req): func selects lookup, insert or delete of key; the
// unused func code acts as a lookup. Response channel (rsp): one word per
// request with status, the key's sorted position and the entry count after
// the operation.
// One request is worked on at a time. Each halving step of a binary search
// over the held entries reads the RAM, then compares. An insert then moves
// every larger key up one entry and a delete moves them down, each moved key
// read through the single RAM read port and then written back, and a final
// step finishes. The result passes through the done state into an output
// register; a request is taken again in the idle state after that, even while
// that response still waits.
// Reset empties the table at once; old RAM contents are never read because
// only read data from entries below the count is ever used.
// If the receiver stalls, a finished result waits in the done state until
// the output register frees up, and no further request is taken.
module sorted_key_set_table #(
  parameter int CAPACITY = 64
) (
  input  wire logic  clk,
  input  wire logic  rst,
  skst_req_if.sink   req,
  skst_rsp_if.source rsp
);

  localparam int AW = $clog2(CAPACITY);
  localparam int CW = $clog2(CAPACITY + 1);

  skst_pkg::state_t  state, state_next;
  logic [CW-1:0]     cnt;
  logic [CW-1:0]     lo, hi;
  logic              held;
  logic [AW-1:0]     j;
  skst_pkg::func_t   op_r;
  skst_pkg::key_t    key_r;
  skst_pkg::status_t status_r;

  logic [CW:0]       mid_sum;
  logic [CW-1:0]     mid_cw;
  logic [AW-1:0]     mid;
  logic [CW-1:0]     j_cw;
  logic              search_end;
  logic              do_ins;
  logic              do_del;
  logic              out_free;

  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  skst_pkg::key_t    ram_wdata;
  logic [AW-1:0]     ram_raddr;
  skst_pkg::key_t    ram_rdata;

  logic [CW+6:0]     pos_ext;
  logic [CW+6:0]     cnt_ext;

  skst_ram #(
    .WIDTH (skst_pkg::KEY_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign mid_sum    = {1'b0, lo} + {1'b0, hi};
  assign mid_cw     = mid_sum[CW:1];
  assign mid        = mid_sum[AW:1];
  assign j_cw       = CW'(j);
  assign search_end = !(lo < hi);
  assign do_ins     = (op_r == skst_pkg::OP_INSERT) && !held && (cnt < CW'(CAPACITY));
  assign do_del     = (op_r == skst_pkg::OP_DELETE) && held;
  assign out_free   = !rsp.valid || rsp.ready;
  assign req.ready  = (state == skst_pkg::S_IDLE);
  assign pos_ext    = {7'd0, lo};
  assign cnt_ext    = {7'd0, cnt};

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      skst_pkg::S_IDLE: begin
        if (req.valid) state_next = skst_pkg::S_LOOK;
      end
      skst_pkg::S_LOOK: begin
        if (!search_end) begin
          state_next = skst_pkg::S_CMP;
        end else if (do_ins) begin
          state_next = (cnt > lo) ? skst_pkg::S_INS_RD : skst_pkg::S_INS_PUT;
        end else if (do_del) begin
          state_next = ((lo + CW'(1)) < cnt) ? skst_pkg::S_DEL_RD : skst_pkg::S_DEL_FIN;
        end else begin
          state_next = skst_pkg::S_DONE;
        end
      end
      skst_pkg::S_CMP:     state_next = skst_pkg::S_LOOK;
      skst_pkg::S_INS_RD:  state_next = skst_pkg::S_INS_WR;
      skst_pkg::S_INS_WR: begin
        state_next = (j_cw == lo) ? skst_pkg::S_INS_PUT : skst_pkg::S_INS_RD;
      end
      skst_pkg::S_INS_PUT: state_next = skst_pkg::S_DONE;
      skst_pkg::S_DEL_RD:  state_next = skst_pkg::S_DEL_WR;
      skst_pkg::S_DEL_WR: begin
        state_next = ((j_cw + CW'(1)) == cnt) ? skst_pkg::S_DEL_FIN : skst_pkg::S_DEL_RD;
      end
      skst_pkg::S_DEL_FIN: state_next = skst_pkg::S_DONE;
      skst_pkg::S_DONE: begin
        if (out_free) state_next = skst_pkg::S_IDLE;
      end
      default:             state_next = skst_pkg::S_IDLE;
    endcase
  end

  // RAM control.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = j;
    ram_wdata = ram_rdata;
    ram_raddr = mid;
    unique case (state)
      skst_pkg::S_INS_RD,
      skst_pkg::S_DEL_RD: ram_raddr = j;
      skst_pkg::S_INS_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j + AW'(1);
      end
      skst_pkg::S_DEL_WR: begin
        ram_we    = 1'b1;
        ram_waddr = j - AW'(1);
      end
      skst_pkg::S_INS_PUT: begin
        ram_we    = 1'b1;
        ram_waddr = AW'(lo);
        ram_wdata = key_r;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= skst_pkg::S_IDLE;
      cnt       <= '0;
      rsp.valid <= 1'b0;
    end else begin
      state <= state_next;
      // A new word loaded in the done state replaces the one just taken.
      if (rsp.valid && rsp.ready && (state != skst_pkg::S_DONE)) rsp.valid <= 1'b0;
      unique case (state)
        skst_pkg::S_IDLE: begin
          if (req.valid) begin
            op_r  <= req.func;
            key_r <= req.key;
            lo    <= '0;
            hi    <= cnt;
            held  <= 1'b0;
          end
        end
        skst_pkg::S_LOOK: begin
          if (search_end) begin
            if (do_ins) begin
              status_r <= skst_pkg::ST_DONE;
              j        <= AW'(cnt - CW'(1));
            end else if (do_del) begin
              status_r <= skst_pkg::ST_DONE;
              j        <= AW'(lo + CW'(1));
            end else if (op_r == skst_pkg::OP_INSERT) begin
              status_r <= held ? skst_pkg::ST_DUP : skst_pkg::ST_FULL;
            end else begin
              status_r <= held ? skst_pkg::ST_DONE : skst_pkg::ST_ABSENT;
            end
          end
        end
        skst_pkg::S_CMP: begin
          // Keys are unique, so a hit pins the search at that entry.
          if (key_r > ram_rdata) begin
            lo <= mid_cw + CW'(1);
          end else begin
            hi <= mid_cw;
          end
          if (key_r == ram_rdata) held <= 1'b1;
        end
        skst_pkg::S_INS_WR: begin
          if (j_cw != lo) j <= j - AW'(1);
        end
        skst_pkg::S_INS_PUT: cnt <= cnt + CW'(1);
        skst_pkg::S_DEL_WR:  j <= j + AW'(1);
        skst_pkg::S_DEL_FIN: cnt <= cnt - CW'(1);
        skst_pkg::S_DONE: begin
          if (out_free) begin
            rsp.valid       <= 1'b1;
            rsp.status      <= status_r;
            rsp.position    <= pos_ext[6:0];
            rsp.entry_count <= cnt_ext[6:0];
          end
        end
        default: begin
        end
      endcase
    end
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (rst)
    cnt <= CW'(CAPACITY))
    else $error("entry count above capacity");

  a_write_op: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (op_r == skst_pkg::OP_INSERT || op_r == skst_pkg::OP_DELETE))
    else $error("table written by a lookup");

  a_search_range: assert property (@(posedge clk) disable iff (rst)
    (state == skst_pkg::S_LOOK) |-> (lo <= hi && hi <= cnt))
    else $error("search bounds crossed");

  a_cnt_hold: assert property (@(posedge clk) disable iff (rst)
    !(state == skst_pkg::S_INS_PUT || state == skst_pkg::S_DEL_FIN) |=> $stable(cnt))
    else $error("entry count changed outside an insert or delete");

endmodule
`default_nettype wire

FILE: src/skst_ram.sv
`default_nettype none
module skst_ram #(
  parameter int WIDTH = 31,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire
